// ===== sv/gspid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gspid_pkg: shared types and constants
// Widths, scaling constants and the result bundle of the gain-scheduled
// PID motor drive.
// ----------------------------------------------------------------------------
package gspid_pkg;

  // Field widths
  localparam int unsigned SpanW   = 15;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned TargetW = 14;
  localparam int unsigned LevelW  = 8;

  // Control sum in thousandths of an output unit, signed
  localparam int unsigned SumW    = 29;

  // Saturation: |S| at or above this gives the maximum drive level
  localparam logic [SumW-1:0]   SatLimit = 29'd150000;
  localparam logic [LevelW-1:0] DriveMax = 8'd150;

  // Divide by 1000 as multiply by ceil(2^28 / 1000), exact for |S| < 150000
  localparam int unsigned       DivIn    = 18;
  localparam int unsigned       DivShift = 28;
  localparam int unsigned       RecipW   = 19;
  localparam logic [RecipW-1:0] DivRecip = 19'd268436;

  // Result item bundle
  typedef struct packed {
    logic              motor_on;
    logic              turn_right;
    logic [LevelW-1:0] drive_level;
  } drive_t;

endpackage : gspid_pkg
`default_nettype wire

// ===== sv/gspid_law.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gspid_law: scheduled control law
// Error, wrapped integral and derivative, band selection by encoder span,
// and the fixed-point control sum S in thousandths.
// ----------------------------------------------------------------------------
module gspid_law
  import gspid_pkg::*;
(
  input  wire logic [ByteW-1:0]          setpoint_byte_i,
  input  wire logic signed [PosW-1:0]    encoder_position_i,
  input  wire logic [ByteW-1:0]          kp_code_i,
  input  wire logic [ByteW-1:0]          ki_code_i,
  input  wire logic [ByteW-1:0]          kd_code_i,
  input  wire logic [SpanW-1:0]          encoder_span_i,
  input  wire logic signed [PosW-1:0]    error_sum_i,
  input  wire logic signed [PosW-1:0]    prev_error_i,
  output logic [TargetW-1:0]             target_position_o,
  output logic signed [PosW-1:0]         error_o,
  output logic signed [PosW-1:0]         error_sum_o,
  output logic signed [SumW-1:0]         ctrl_sum_o
);

  logic [PosW-1:0]          target_w;
  logic signed [PosW-1:0]   deriv;
  logic [PosW:0]            err_mag;
  logic [19:0]              err_mag10;
  logic [19:0]              span6;
  logic signed [24:0]       p_term;
  logic signed [24:0]       i_term;
  logic signed [24:0]       kd_prod;
  logic signed [SumW-1:0]   d_term;

  // target = 60 * byte = 64*byte - 4*byte
  assign target_w = ({8'd0, setpoint_byte_i} << 6) - ({8'd0, setpoint_byte_i} << 2);
  assign target_position_o = target_w[TargetW-1:0];

  // Error, integral and derivative, all wrapping at 16 bits
  assign error_o     = $signed(target_w - encoder_position_i);
  assign error_sum_o = error_sum_i + error_o;
  assign deriv       = error_o - prev_error_i;

  // Band limits: 10*|e| against span and 6*span
  assign err_mag   = error_o[PosW-1] ? (17'd0 - {error_o[PosW-1], error_o})
                                     : {1'b0, error_o};
  assign err_mag10 = {err_mag, 3'b000} + {2'b00, err_mag, 1'b0};
  assign span6     = {4'd0, encoder_span_i, 1'b0} + {3'd0, encoder_span_i, 2'b00};

  // Gain products, gain codes unsigned
  assign p_term  = $signed({1'b0, kp_code_i}) * error_o;
  assign i_term  = $signed({1'b0, ki_code_i}) * error_sum_o;
  assign kd_prod = $signed({1'b0, kd_code_i}) * deriv;
  assign d_term  = (SumW'(kd_prod) <<< 3) + (SumW'(kd_prod) <<< 1);

  // Term selection
  always_comb begin
    if (err_mag10 < {5'd0, encoder_span_i}) begin
      ctrl_sum_o = SumW'(p_term) + d_term;
    end else if (err_mag10 < span6) begin
      ctrl_sum_o = SumW'(p_term);
    end else begin
      ctrl_sum_o = SumW'(p_term) + SumW'(i_term);
    end
  end

endmodule : gspid_law
`default_nettype wire

// ===== sv/gspid_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gspid_scale: output scaling
// Sign to enable and direction, |S|/1000 truncated and saturated at 150.
// ----------------------------------------------------------------------------
module gspid_scale
  import gspid_pkg::*;
(
  input  wire logic signed [SumW-1:0] ctrl_sum_i,
  output drive_t                      drive_o
);

  logic [SumW-1:0]         sum_mag;
  logic [DivIn+RecipW-1:0] quot_prod;

  assign sum_mag   = ctrl_sum_i[SumW-1] ? (SumW'(0) - ctrl_sum_i) : ctrl_sum_i;
  // reciprocal multiply, only used below the saturation limit
  assign quot_prod = sum_mag[DivIn-1:0] * DivRecip;

  always_comb begin
    drive_o.motor_on   = (ctrl_sum_i != '0);
    drive_o.turn_right = !ctrl_sum_i[SumW-1] && (ctrl_sum_i != '0);
    if (sum_mag >= SatLimit) begin
      drive_o.drive_level = DriveMax;
    end else begin
      drive_o.drive_level = quot_prod[DivShift +: LevelW];
    end
  end

endmodule : gspid_scale
`default_nettype wire

// ===== sv/gain_scheduled_pid_motor_drive.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gain_scheduled_pid_motor_drive: gain-scheduled PID position controller
// One control update per item; P+D, P or P+I chosen by error band.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  cfg     | in        | cfg_we_i                  | cfg_wdata_i (encoder span)
//  in      | in        | in_valid_i / in_ready_o   | setpoint, position, gains
//  out     | out       | out_valid_o / out_ready_i | enable, direction, level, target
//
// Three register stages: input, control sum, result. A result is valid once
// its item reaches the result stage; one item per cycle sustained while
// out_ready_i is high. Integral and last error update as an item leaves the
// input stage. A stage loads whenever it is empty or its contents move on,
// so out_ready_i reaches in_ready_o in the same cycle and the input stalls
// only while all three stages are full and the output is held.
// Reset clears the valid bits, integral and last error, and the encoder span.
// ----------------------------------------------------------------------------
module gain_scheduled_pid_motor_drive
  import gspid_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [SpanW-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [ByteW-1:0]        setpoint_byte_i,
  input  wire logic signed [PosW-1:0]  encoder_position_i,
  input  wire logic [ByteW-1:0]        kp_code_i,
  input  wire logic [ByteW-1:0]        ki_code_i,
  input  wire logic [ByteW-1:0]        kd_code_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         motor_on_o,
  output logic                         turn_right_o,
  output logic [LevelW-1:0]            drive_level_o,
  output logic [TargetW-1:0]           target_position_o
);

  logic [SpanW-1:0]        span_q;
  logic signed [PosW-1:0]  err_sum_q, err_sum_d;
  logic signed [PosW-1:0]  prev_err_q, err_d;

  // stage 0: input register
  logic                    v0_q;
  logic [ByteW-1:0]        sp_q, kp_q, ki_q, kd_q;
  logic signed [PosW-1:0]  pos_q;

  // stage 1: control sum
  logic                    v1_q;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [TargetW-1:0]      tgt1_q, tgt_d;

  // stage 2: result
  logic                    v2_q;
  drive_t                  drv_q, drv_d;
  logic [TargetW-1:0]      tgt2_q;

  logic adv0, adv1, adv2;

  // stage enables
  assign adv2 = !v2_q || out_ready_i;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;
  assign in_ready_o = adv0;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
    end else if (cfg_we_i) begin
      span_q <= cfg_wdata_i;
    end
  end

  gspid_law u_law (
    .setpoint_byte_i   (sp_q),
    .encoder_position_i(pos_q),
    .kp_code_i         (kp_q),
    .ki_code_i         (ki_q),
    .kd_code_i         (kd_q),
    .encoder_span_i    (span_q),
    .error_sum_i       (err_sum_q),
    .prev_error_i      (prev_err_q),
    .target_position_o (tgt_d),
    .error_o           (err_d),
    .error_sum_o       (err_sum_d),
    .ctrl_sum_o        (sum_d)
  );

  gspid_scale u_scale (
    .ctrl_sum_i(sum_q),
    .drive_o   (drv_d)
  );

  // valid bits and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      err_sum_q  <= '0;
      prev_err_q <= '0;
    end else begin
      if (adv0) v0_q <= in_valid_i;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (v0_q && adv1) begin
        err_sum_q  <= err_sum_d;
        prev_err_q <= err_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv0 && in_valid_i) begin
      sp_q  <= setpoint_byte_i;
      pos_q <= encoder_position_i;
      kp_q  <= kp_code_i;
      ki_q  <= ki_code_i;
      kd_q  <= kd_code_i;
    end
    if (adv1 && v0_q) begin
      sum_q  <= sum_d;
      tgt1_q <= tgt_d;
    end
    if (adv2 && v1_q) begin
      drv_q  <= drv_d;
      tgt2_q <= tgt1_q;
    end
  end

  // outputs
  assign out_valid_o       = v2_q;
  assign motor_on_o        = drv_q.motor_on;
  assign turn_right_o      = drv_q.turn_right;
  assign drive_level_o     = drv_q.drive_level;
  assign target_position_o = tgt2_q;

`ifndef SYNTHESIS
  // a driven level implies enabled
  a_level_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && drive_level_o != '0) |-> motor_on_o)
    else $error("drive level without enable");

  // disabled motor has no direction or level
  a_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !motor_on_o) |-> (!turn_right_o && drive_level_o == '0))
    else $error("disabled result not zero");

  // level saturates
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_level_o <= DriveMax))
    else $error("drive level above limit");

  // last error updates only when an item leaves the input stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v0_q && adv1) |=> $stable(prev_err_q) && $stable(err_sum_q))
    else $error("controller state changed without an item");
`endif

endmodule : gain_scheduled_pid_motor_drive
`default_nettype wire
